>>> rtl/elf_hdr_pkg.sv
package elf_hdr_pkg;

    localparam int unsigned POS_W = 7;
    localparam int unsigned ID_W  = 5;

    localparam logic [7:0] MAGIC [4] = '{8'h7f, 8'h45, 8'h4c, 8'h46};

    localparam logic [1:0] CLASS_32 = 2'd1;
    localparam logic [1:0] CLASS_64 = 2'd2;
    localparam logic [1:0] ORDER_LSB = 2'd1;
    localparam logic [1:0] ORDER_MSB = 2'd2;

    localparam logic [POS_W-1:0] HDR_LEN_32 = 7'd52;
    localparam logic [POS_W-1:0] HDR_LEN_64 = 7'd64;

    localparam logic [ID_W-1:0] ID_PAD = 5'd5;

    typedef enum logic [1:0] {
        ST_FIELD    = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_ERROR    = 2'd2
    } t_status;

    // Position of a header byte within its field.
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [POS_W-1:0] start;
        logic [3:0]       len;
    } t_loc;

    // Work handed from the classifier to the assembler, one per word.
    typedef struct packed {
        logic [7:0]       data;
        logic [2:0]       k;
        logic             lsb_first;
        logic             emit;
        logic             err;
        logic             done;
        logic [ID_W-1:0]  id;
        logic [POS_W-1:0] count;
    } t_cmd;

    function automatic t_loc f_locate(input logic [POS_W-1:0] p, input logic wide);
        t_loc             l;
        logic [POS_W-1:0] k;
        l.id    = '0;
        l.start = p;
        l.len   = 4'd1;
        k       = '0;
        if (p <= 7'd8) begin
            l.id    = ID_W'(p - 7'd4);
            l.start = p;
            l.len   = 4'd1;
        end else if (p < 7'd16) begin
            l.id    = ID_PAD;
            l.start = 7'd9;
            l.len   = 4'd7;
        end else if (p < 7'd18) begin
            l.id    = 5'd6;
            l.start = 7'd16;
            l.len   = 4'd2;
        end else if (p < 7'd20) begin
            l.id    = 5'd7;
            l.start = 7'd18;
            l.len   = 4'd2;
        end else if (p < 7'd24) begin
            l.id    = 5'd8;
            l.start = 7'd20;
            l.len   = 4'd4;
        end else if (!wide) begin
            if (p < 7'd40) begin
                k       = (p - 7'd24) >> 2;
                l.id    = ID_W'(7'd9 + k);
                l.start = 7'd24 + (k << 2);
                l.len   = 4'd4;
            end else begin
                k       = (p - 7'd40) >> 1;
                l.id    = ID_W'(7'd13 + k);
                l.start = 7'd40 + (k << 1);
                l.len   = 4'd2;
            end
        end else if (p < 7'd48) begin
            k       = (p - 7'd24) >> 3;
            l.id    = ID_W'(7'd9 + k);
            l.start = 7'd24 + (k << 3);
            l.len   = 4'd8;
        end else if (p < 7'd52) begin
            l.id    = 5'd12;
            l.start = 7'd48;
            l.len   = 4'd4;
        end else begin
            k       = (p - 7'd52) >> 1;
            l.id    = ID_W'(7'd13 + k);
            l.start = 7'd52 + (k << 1);
            l.len   = 4'd2;
        end
        return l;
    endfunction

endpackage

>>> rtl/elf_hdr_if.sv
interface elf_hdr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface elf_hdr_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  field_id;
    logic [63:0] field_value;
    logic [1:0]  status;
    logic [6:0]  bytes_consumed;

    modport source (output valid, output field_id, output field_value, output status,
                    output bytes_consumed, input ready);
    modport sink   (input valid, input field_id, input field_value, input status,
                    input bytes_consumed, output ready);
endinterface

>>> rtl/elf_hdr_front.sv
module elf_hdr_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    elf_hdr_in_if.sink          i_in,
    input  logic                i_full,
    output logic                o_push,
    output elf_hdr_pkg::t_cmd   o_cmd
);
    import elf_hdr_pkg::*;

    typedef enum logic [2:0] {
        PH_PARSE = 3'b001,
        PH_DONE  = 3'b010,
        PH_ERROR = 3'b100
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [1:0]       r_class, n_class;
    logic [1:0]       r_order, n_order;

    logic             accept;
    logic             is_magic;
    logic             chk_err;
    logic             wide;
    t_loc             loc;
    logic [2:0]       k;
    logic             last;
    logic             done;
    logic             err;
    logic [7:0]       b;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] total;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign b          = i_in.data_byte;
    assign pos_inc    = r_pos + 7'd1;
    assign is_magic   = (r_pos < 7'd4);

    always_comb begin
        chk_err = 1'b0;
        n_class = r_class;
        n_order = r_order;
        if (is_magic) begin
            chk_err = (b != MAGIC[r_pos[1:0]]);
        end else if (r_pos == 7'd4) begin
            if (b[7:2] == '0 && (b[1:0] == CLASS_32 || b[1:0] == CLASS_64)) begin
                n_class = b[1:0];
            end else begin
                chk_err = 1'b1;
            end
        end else if (r_pos == 7'd5) begin
            if (b[7:2] == '0 && (b[1:0] == ORDER_LSB || b[1:0] == ORDER_MSB)) begin
                n_order = b[1:0];
            end else begin
                chk_err = 1'b1;
            end
        end
    end

    assign wide  = (n_class == CLASS_64);
    assign loc   = f_locate(r_pos, wide);
    assign k     = 3'(r_pos - loc.start);
    assign total = wide ? HDR_LEN_64 : HDR_LEN_32;
    assign last  = !is_magic && ({1'b0, k} == loc.len - 4'd1);
    assign done  = !is_magic && !chk_err && (pos_inc == total);
    // A buffer that ends short of the full header is an error on its last word.
    assign err   = chk_err || (i_in.end_of_buffer && !done);

    always_comb begin
        o_cmd.data      = b;
        o_cmd.k         = k;
        o_cmd.lsb_first = (loc.id == ID_PAD) || (n_order == ORDER_LSB);
        o_cmd.emit      = err || last;
        o_cmd.err       = err;
        o_cmd.done      = done;
        o_cmd.id        = loc.id;
        o_cmd.count     = pos_inc;
    end

    assign o_push = accept && (r_phase == PH_PARSE) && (!is_magic || err);

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        if (accept) begin
            if (i_in.end_of_buffer) begin
                n_phase = PH_PARSE;
                n_pos   = '0;
            end else if (r_phase == PH_PARSE) begin
                n_pos = pos_inc;
                if (err) begin
                    n_phase = PH_ERROR;
                end else if (done) begin
                    n_phase = PH_DONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PARSE;
            r_pos   <= '0;
            r_class <= '0;
            r_order <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            if (accept && i_in.end_of_buffer) begin
                r_class <= '0;
                r_order <= '0;
            end else if (accept && r_phase == PH_PARSE) begin
                r_class <= n_class;
                r_order <= n_order;
            end
        end
    end

    a_err_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_cmd.err && !i_in.end_of_buffer) |=> (r_phase == PH_ERROR))
        else $error("error word did not stop the parser");

endmodule

>>> rtl/elf_hdr_queue.sv
module elf_hdr_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  elf_hdr_pkg::t_cmd i_cmd,
    input  logic              i_pop,
    output elf_hdr_pkg::t_cmd o_cmd,
    output logic              o_full,
    output logic              o_empty
);
    import elf_hdr_pkg::*;

    localparam int unsigned DEPTH = 2;

    t_cmd       r_mem [DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(DEPTH))
        else $error("queue fill count out of range");

endmodule

>>> rtl/elf_hdr_back.sv
module elf_hdr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  elf_hdr_pkg::t_cmd i_cmd,
    input  logic              i_empty,
    output logic              o_pop,
    elf_hdr_out_if.source     o_out
);
    import elf_hdr_pkg::*;

    logic [63:0]      r_acc, n_acc;
    logic             r_valid;
    logic [ID_W-1:0]  r_id;
    logic [63:0]      r_value;
    t_status          r_status;
    logic [POS_W-1:0] r_count;

    logic [63:0] acc_base;
    logic        take;

    assign take  = r_valid && o_out.ready;
    assign o_pop = !i_empty && (!r_valid || o_out.ready);

    // The first word of a field starts a fresh value; the pad field and
    // little-endian files place each word above the previous one.
    always_comb begin
        acc_base = (i_cmd.k == '0) ? '0 : r_acc;
        if (i_cmd.lsb_first) begin
            n_acc = acc_base | ({56'd0, i_cmd.data} << {i_cmd.k, 3'b000});
        end else begin
            n_acc = {acc_base[55:0], i_cmd.data};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_acc <= n_acc;
        end
        if (o_pop && i_cmd.emit) begin
            if (i_cmd.err) begin
                r_id     <= '0;
                r_value  <= '0;
                r_status <= ST_ERROR;
            end else begin
                r_id     <= i_cmd.id;
                r_value  <= n_acc;
                r_status <= i_cmd.done ? ST_COMPLETE : ST_FIELD;
            end
            r_count <= i_cmd.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop && i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (take) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.field_id       = r_id;
    assign o_out.field_value    = r_value;
    assign o_out.status         = r_status;
    assign o_out.bytes_consumed = r_count;

    a_pop_frees_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cmd.emit) |=> r_valid)
        else $error("emitted word lost from output register");

endmodule

>>> rtl/elf_hdr_top.sv
// ELF file header parser.
// Input channel: one image byte per word, with end_of_buffer on the last byte
// of a buffer. Output channel: one word per completed header field carrying its
// id, value (in the file's byte order), status and the header bytes taken.
// The last field of a good header has status complete and a count of 52 or 64;
// a bad magic, class or data byte, or a buffer that ends early, gives a single
// error word and the fields already sent are to be dropped.
// After completion or error, bytes are swallowed until end_of_buffer rearms.
// Throughput is one byte per cycle while the queue is not full. A result for the byte
// that completes its field goes from the combinational classifier into the two-entry
// queue, and from there into the assembler's output register.
// When the receiver stalls, the output register and then the queue fill, and
// ready on the input drops once the queue is full; nothing is lost.
// Reset (synchronous, active low) clears the parse position, queue and output
// valid; the first byte may be presented in the cycle after reset is released.
module elf_file_header_parser_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    elf_hdr_in_if.sink    i_in,
    elf_hdr_out_if.source o_out
);
    import elf_hdr_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    elf_hdr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    elf_hdr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    elf_hdr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (queue_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

>>> test/elf_hdr_check.sv
module elf_hdr_check (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [7:0]                    i_in_data,
    input  logic                          i_in_eob,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [elf_hdr_pkg::ID_W-1:0]  i_out_id,
    input  logic [63:0]                   i_out_value,
    input  logic [1:0]                    i_out_status,
    input  logic [elf_hdr_pkg::POS_W-1:0] i_out_count,
    output int unsigned                   o_fail_count,
    output int unsigned                   o_pending
);
    import elf_hdr_pkg::*;

    localparam logic [ID_W-1:0] FID_CLASS   = 5'd0;
    localparam logic [ID_W-1:0] FID_TYPE    = 5'd6;
    localparam logic [ID_W-1:0] FID_MACHINE = 5'd7;
    localparam logic [ID_W-1:0] FID_VERSION = 5'd8;
    localparam logic [ID_W-1:0] FID_ENTRY   = 5'd9;
    localparam logic [ID_W-1:0] FID_FLAGS   = 5'd12;
    localparam logic [ID_W-1:0] FID_EHSIZE  = 5'd13;
    localparam int unsigned     REPORT_MAX  = 10;

    typedef enum logic [1:0] {
        PH_PARSING = 2'd0,
        PH_DONE    = 2'd1,
        PH_ERROR   = 2'd2
    } t_parser_phase;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [63:0]      value;
        t_status          status;
        logic [POS_W-1:0] count;
    } t_field_word;

    logic [POS_W-1:0] hdr_pos;
    logic [1:0]       elf_class;
    logic [1:0]       elf_order;
    logic [63:0]      field_acc;
    t_parser_phase    parser_phase;
    t_field_word      field_words_due [$];
    int unsigned      mismatch_count;

    task automatic rearm();
        hdr_pos      = '0;
        elf_class    = '0;
        elf_order    = '0;
        field_acc    = '0;
        parser_phase = PH_PARSING;
    endtask

    // Which field header byte p belongs to, where that field starts and how long it is.
    function automatic void field_span(input logic [POS_W-1:0] p, input logic wide,
                                       output logic [ID_W-1:0] fid,
                                       output logic [POS_W-1:0] first,
                                       output logic [3:0] flen);
        if (p <= 7'd8) begin
            fid = FID_CLASS + ID_W'(p - 7'd4); first = p; flen = 4'd1;
        end else if (p < 7'd16) begin
            fid = ID_PAD; first = 7'd9; flen = 4'd7;
        end else if (p < 7'd18) begin
            fid = FID_TYPE; first = 7'd16; flen = 4'd2;
        end else if (p < 7'd20) begin
            fid = FID_MACHINE; first = 7'd18; flen = 4'd2;
        end else if (p < 7'd24) begin
            fid = FID_VERSION; first = 7'd20; flen = 4'd4;
        end else if (!wide && p < 7'd40) begin
            fid = FID_ENTRY + ID_W'((p - 7'd24) >> 2); first = p & ~7'd3; flen = 4'd4;
        end else if (!wide) begin
            fid = FID_EHSIZE + ID_W'((p - 7'd40) >> 1); first = p & ~7'd1; flen = 4'd2;
        end else if (p < 7'd48) begin
            fid = FID_ENTRY + ID_W'((p - 7'd24) >> 3); first = p & ~7'd7; flen = 4'd8;
        end else if (p < 7'd52) begin
            fid = FID_FLAGS; first = 7'd48; flen = 4'd4;
        end else begin
            fid = FID_EHSIZE + ID_W'((p - 7'd52) >> 1); first = p & ~7'd1; flen = 4'd2;
        end
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic eob);
        logic [POS_W-1:0] p;
        logic [ID_W-1:0]  fid;
        logic [POS_W-1:0] first;
        logic [3:0]       flen;
        logic [2:0]       k;
        logic             wide;
        logic             bad;
        logic             last;
        logic             done;
        t_field_word      w;
        p     = hdr_pos;
        bad   = 1'b0;
        last  = 1'b0;
        done  = 1'b0;
        fid   = '0;
        first = '0;
        flen  = 4'd1;
        if (parser_phase == PH_PARSING) begin
            if (p < 7'd4) begin
                bad = (b != MAGIC[p[1:0]]);
            end else begin
                if (p == 7'd4) begin
                    if (b == {6'd0, CLASS_32} || b == {6'd0, CLASS_64}) elf_class = b[1:0];
                    else bad = 1'b1;
                end else if (p == 7'd5) begin
                    if (b == {6'd0, ORDER_LSB} || b == {6'd0, ORDER_MSB}) elf_order = b[1:0];
                    else bad = 1'b1;
                end
                if (!bad) begin
                    wide = (elf_class == CLASS_64);
                    field_span(p, wide, fid, first, flen);
                    k = 3'(p - first);
                    if (k == 3'd0) field_acc = '0;
                    // The pad bytes go in least significant first whatever the byte order.
                    if (fid == ID_PAD || elf_order == ORDER_LSB) begin
                        field_acc |= {56'd0, b} << {k, 3'b000};
                    end else begin
                        field_acc = {field_acc[55:0], b};
                    end
                    last = ({1'b0, k} == flen - 4'd1);
                    done = (p + 7'd1 == (wide ? HDR_LEN_64 : HDR_LEN_32));
                end
            end
            hdr_pos = p + 7'd1;
            // A buffer that ends short of a whole header overrides any field it completes.
            if (eob && !done) bad = 1'b1;
            if (bad) begin
                w.id     = '0;
                w.value  = '0;
                w.status = ST_ERROR;
                w.count  = hdr_pos;
                field_words_due.push_back(w);
                parser_phase = PH_ERROR;
            end else if (last) begin
                w.id     = fid;
                w.value  = field_acc;
                w.status = done ? ST_COMPLETE : ST_FIELD;
                w.count  = hdr_pos;
                field_words_due.push_back(w);
                if (done) parser_phase = PH_DONE;
            end
        end
        if (eob) rearm();
    endtask

    always @(posedge i_clk) begin
        t_field_word seen;
        t_field_word want;
        if (!i_rst_n) begin
            rearm();
            field_words_due.delete();
            mismatch_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                seen.id     = i_out_id;
                seen.value  = i_out_value;
                seen.status = t_status'(i_out_status);
                seen.count  = i_out_count;
                if (field_words_due.size() == 0) begin
                    if (mismatch_count < REPORT_MAX) begin
                        $display("%0t: unexpected word: id %0d value %h status %0d count %0d",
                                 $time, seen.id, seen.value, seen.status, seen.count);
                    end
                    mismatch_count++;
                end else begin
                    want = field_words_due.pop_front();
                    if (seen !== want) begin
                        if (mismatch_count < REPORT_MAX) begin
                            $display("%0t: expected id %0d value %h status %0d count %0d",
                                     $time, want.id, want.value, want.status, want.count);
                            $display("%0t:      got id %0d value %h status %0d count %0d",
                                     $time, seen.id, seen.value, seen.status, seen.count);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) parse_byte(i_in_data, i_in_eob);
        end
        o_fail_count <= mismatch_count;
        o_pending    <= field_words_due.size();
    end

endmodule

>>> test/elf_file_header_parser_core_test.sv
module elf_file_header_parser_core_test;
    import elf_hdr_pkg::*;

    localparam int unsigned ITEM_TARGET = 450;
    localparam int unsigned QUIET_FROM  = 370;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned IDLE_LIMIT  = 3000;
    localparam int unsigned DRAIN_WAIT  = 10;

    typedef enum int unsigned {
        SEQ_GOOD,
        SEQ_TRUNCATED,
        SEQ_BAD_IDENT,
        SEQ_NOISE
    } t_seq_kind;

    logic        i_clk;
    logic        i_rst_n;
    int unsigned fail_count;
    int unsigned pending;
    bit          tx_gaps;
    bit          rx_stalls;
    bit          hold_req;
    int unsigned parsed;

    elf_hdr_in_if  in_if ();
    elf_hdr_out_if out_if ();

    elf_file_header_parser_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    elf_hdr_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_if.valid),
        .i_in_ready   (in_if.ready),
        .i_in_data    (in_if.data_byte),
        .i_in_eob     (in_if.end_of_buffer),
        .i_out_valid  (out_if.valid),
        .i_out_ready  (out_if.ready),
        .i_out_id     (out_if.field_id),
        .i_out_value  (out_if.field_value),
        .i_out_status (out_if.status),
        .i_out_count  (out_if.bytes_consumed),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Returns at the edge where the word is taken, with valid still high.
    task automatic send_byte(input logic [7:0] b, input logic eob);
        if (tx_gaps && $urandom_range(0, 7) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.data_byte     <= b;
        in_if.end_of_buffer <= eob;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    task automatic send_magic();
        for (int i = 0; i < 4; i++) send_byte(MAGIC[i], 1'b0);
    endtask

    task automatic send_image(input t_seq_kind kind, input logic [1:0] cls);
        logic [7:0]  img [72];
        int unsigned span;
        int unsigned len;
        int unsigned cut;
        int unsigned r;
        span = (cls == CLASS_64) ? HDR_LEN_64 : HDR_LEN_32;
        for (int i = 0; i < 72; i++) begin
            r = $urandom_range(0, 9);
            img[i] = (r == 0) ? 8'h00 : (r == 1) ? 8'hff : 8'($urandom_range(0, 255));
        end
        if (kind != SEQ_NOISE) begin
            for (int i = 0; i < 4; i++) img[i] = MAGIC[i];
            img[4] = {6'd0, cls};
            img[5] = $urandom_range(0, 1) ? {6'd0, ORDER_MSB} : {6'd0, ORDER_LSB};
        end
        case (kind)
            SEQ_GOOD: begin
                len = span + $urandom_range(0, 3);
                parsed += span;
            end
            SEQ_TRUNCATED: begin
                len = $urandom_range(1, span - 1);
                parsed += len;
            end
            SEQ_BAD_IDENT: begin
                cut = $urandom_range(0, 5);
                r   = $urandom_range(0, 253);
                if (cut < 4) img[cut] = MAGIC[cut] ^ 8'($urandom_range(1, 255));
                else img[cut] = (r == 0) ? 8'h00 : 8'(r + 2);
                len = cut + 1 + $urandom_range(0, 4);
                parsed += cut + 1;
            end
            default: begin
                len = $urandom_range(1, 8);
                parsed += 1;
            end
        endcase
        for (int i = 0; i < len; i++) send_byte(img[i], i == len - 1);
    endtask

    initial begin : stimulus
        int unsigned r;
        t_seq_kind   kind;
        i_rst_n             <= 1'b0;
        in_if.valid         <= 1'b0;
        in_if.data_byte     <= '0;
        in_if.end_of_buffer <= 1'b0;
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        hold_req  = 1'b0;
        parsed    = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Bad first magic byte, then bytes swallowed until the end of the buffer.
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h7f, 1'b1);
        // Buffer of one good magic byte.
        send_byte(MAGIC[0], 1'b1);
        // Invalid class, then a swallowed end of buffer.
        send_magic();
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b1);
        // Invalid data byte which also ends the buffer.
        send_magic();
        send_byte({6'd0, CLASS_64}, 1'b0);
        send_byte(8'hff, 1'b1);
        // The buffer ends on a byte that completes field 2, the byte after the data byte.
        send_magic();
        send_byte({6'd0, CLASS_32}, 1'b0);
        send_byte({6'd0, ORDER_MSB}, 1'b0);
        send_byte(8'hff, 1'b1);

        // The receiver holds off while a whole header is offered without gaps.
        tx_gaps  = 1'b0;
        hold_req = 1'b1;
        send_image(SEQ_GOOD, CLASS_64);

        while (parsed < ITEM_TARGET) begin
            if (parsed >= QUIET_FROM) begin
                tx_gaps   = 1'b0;
                rx_stalls = 1'b0;
            end else begin
                tx_gaps = ($urandom_range(0, 3) != 0);
            end
            r = $urandom_range(0, 9);
            kind = (r < 6) ? SEQ_GOOD : (r < 8) ? SEQ_TRUNCATED : (r < 9) ? SEQ_BAD_IDENT : SEQ_NOISE;
            send_image(kind, $urandom_range(0, 1) ? CLASS_64 : CLASS_32);
        end
        in_if.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : receiver
        int unsigned run;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            run = $urandom_range(1, 30);
            repeat (run) @(posedge i_clk);
        end
    end

    initial begin : watchdog
        int unsigned stuck;
        stuck = 0;
        while (stuck < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                stuck = 0;
            end else begin
                stuck++;
            end
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
